// ===== hdl/rrif_pkg.sv =====
// rrif_pkg: types, sizes and helpers shared by the round-robin idle-first picker
// used by rrif_lane, rrif_merge and round_robin_idle_first_picker
package rrif_pkg;

    localparam int SLOTS   = 16;
    localparam int MASK_W  = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GRANT_W = 4;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [MASK_W-1:0] present_mask;
        logic [MASK_W-1:0] type_ok_mask;
        logic [MASK_W-1:0] link_open_mask;
        logic [MASK_W-1:0] ready_mask;
        logic [MASK_W-1:0] busy_mask;
    } req_t;

    typedef struct packed {
        logic               found;
        logic               busy_fallback;
        logic [GRANT_W-1:0] granted_slot;
    } resp_t;

    // status bits of one slot as seen by its lane
    typedef struct packed {
        logic present;
        logic type_ok;
        logic link_open;
        logic ready;
        logic busy;
    } lane_in_t;

    typedef struct packed {
        logic idle_hit;
        logic busy_hit;
    } lane_flags_t;

    // outcome of the merge, including the pointer to load
    typedef struct packed {
        logic  found;
        logic  busy_fallback;
        slot_t slot;
        slot_t next_ptr;
    } pick_t;

    // (a + b) modulo SLOTS for operands already below SLOTS
    function automatic slot_t wrap_add(input slot_t a, input slot_t b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W+1)'(SLOTS)) begin
            sum = sum - (SLOT_W+1)'(SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ===== hdl/rrif_lane.sv =====
// rrif_lane: per-slot eligibility check, one copy per slot
// depends on rrif_pkg
module rrif_lane (
    input  rrif_pkg::lane_in_t    lane_in,
    output rrif_pkg::lane_flags_t lane_flags
);
    import rrif_pkg::*;

    logic eligible;

    assign eligible = lane_in.present & lane_in.type_ok & lane_in.link_open & lane_in.ready;
    assign lane_flags.idle_hit = eligible & ~lane_in.busy;
    assign lane_flags.busy_hit = eligible & lane_in.busy;

endmodule

// ===== hdl/rrif_merge.sv =====
// rrif_merge: combines lane flags into one grant by a rotated priority search
// depends on rrif_pkg
module rrif_merge (
    input  rrif_pkg::lane_flags_t [rrif_pkg::SLOTS-1:0] lane_flags,
    input  rrif_pkg::slot_t                             start_ptr,
    output rrif_pkg::pick_t                             pick
);
    import rrif_pkg::*;

    logic [SLOTS-1:0] rot_idle;
    logic [SLOTS-1:0] rot_busy;
    slot_t            idle_off;
    slot_t            busy_off;
    slot_t            idle_slot;
    slot_t            busy_slot;

    // rotate so that position 0 is the slot the scan starts at
    always_comb begin
        slot_t idx;
        for (int i = 0; i < SLOTS; i++) begin
            idx = wrap_add(start_ptr, SLOT_W'(i));
            rot_idle[i] = lane_flags[idx].idle_hit;
            rot_busy[i] = lane_flags[idx].busy_hit;
        end
    end

    // first idle hit in scan order, last busy hit in scan order
    always_comb begin
        idle_off = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (rot_idle[i]) begin
                idle_off = SLOT_W'(i);
            end
        end
        busy_off = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (rot_busy[i]) begin
                busy_off = SLOT_W'(i);
            end
        end
    end

    assign idle_slot = wrap_add(start_ptr, idle_off);
    assign busy_slot = wrap_add(start_ptr, busy_off);

    always_comb begin
        pick          = '0;
        pick.next_ptr = start_ptr;
        if (|rot_idle) begin
            pick.found    = 1'b1;
            pick.slot     = idle_slot;
            pick.next_ptr = wrap_add(idle_slot, SLOT_W'(1));
        end else if (|rot_busy) begin
            pick.found         = 1'b1;
            pick.busy_fallback = 1'b1;
            pick.slot          = busy_slot;
        end
    end

endmodule

// ===== hdl/round_robin_idle_first_picker.sv =====
// round_robin_idle_first_picker: top level, slot lanes, merge, pointer and output register
// depends on rrif_pkg, rrif_lane, rrif_merge
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid / s_ready  req_t  (five per-slot status masks)
//   m_*          out  m_valid / m_ready  resp_t (found, busy_fallback, granted_slot)
//
// one request per cycle while s_ready is high; the grant appears on m_* the cycle after acceptance
// the scan pointer and the grant come from one rotated priority search per cycle
// aresetn (synchronous) clears the pointer to slot 0 and empties the output register
// s_ready stays high while the output register is empty or being drained
module round_robin_idle_first_picker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rrif_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rrif_pkg::resp_t m_data
);
    import rrif_pkg::*;

    lane_in_t    [SLOTS-1:0] lane_in;
    lane_flags_t [SLOTS-1:0] lane_flags;
    pick_t                   pick;

    slot_t ptr_reg;
    slot_t ptr_next;
    logic  m_valid_reg;
    logic  m_valid_next;
    resp_t m_data_reg;
    resp_t m_data_next;
    logic  s_take;

    // slots beyond the mask width read as not present
    for (genvar s = 0; s < SLOTS; s++) begin : g_lane
        if (s < MASK_W) begin : g_bits
            assign lane_in[s].present   = s_data.present_mask[s];
            assign lane_in[s].type_ok   = s_data.type_ok_mask[s];
            assign lane_in[s].link_open = s_data.link_open_mask[s];
            assign lane_in[s].ready     = s_data.ready_mask[s];
            assign lane_in[s].busy      = s_data.busy_mask[s];
        end else begin : g_none
            assign lane_in[s] = '0;
        end
        rrif_lane u_lane (
            .lane_in    (lane_in[s]),
            .lane_flags (lane_flags[s])
        );
    end

    rrif_merge u_merge (
        .lane_flags (lane_flags),
        .start_ptr  (ptr_reg),
        .pick       (pick)
    );

    assign s_ready = ~m_valid_reg | m_ready;
    assign s_take  = s_valid & s_ready;

    always_comb begin
        ptr_next     = ptr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_take) begin
            ptr_next                  = pick.next_ptr;
            m_valid_next              = 1'b1;
            m_data_next.found         = pick.found;
            m_data_next.busy_fallback = pick.busy_fallback;
            m_data_next.granted_slot  = GRANT_W'(pick.slot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // pointer only moves on an idle grant
    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && !(pick.found && !pick.busy_fallback)) |=> $stable(ptr_reg))
        else $error("pointer moved without an idle grant");

    // pointer lands just past the idle slot that was granted
    a_ptr_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && pick.found && !pick.busy_fallback)
            |=> ptr_reg == wrap_add($past(pick.slot), SLOT_W'(1)))
        else $error("pointer not one past the granted idle slot");

    // a not-found result carries zero slot and no fallback flag
    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (!m_data.busy_fallback && m_data.granted_slot == '0))
        else $error("not-found result carries slot or fallback");

    // an idle grant must name a slot whose lane reported idle eligibility
    a_idle_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        (pick.found && !pick.busy_fallback) |-> lane_flags[pick.slot].idle_hit)
        else $error("idle grant on a slot that is not idle and eligible");

    // pointer stays inside the slot range
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (SLOT_W+1)'(ptr_reg) < (SLOT_W+1)'(SLOTS))
        else $error("pointer out of range");

endmodule
